// ----- rtl/assert_macros.svh -----
// assertion macros used by the search core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define SPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sps_pkg.sv -----
// shared types and constants of the shortest path search core
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    // metric codes
    localparam logic [1:0] MET_DURATION = 2'd0;
    localparam logic [1:0] MET_PRICE    = 2'd1;
    localparam logic [1:0] MET_LEVEL    = 2'd2;
    localparam logic [1:0] MET_RSVD     = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOPATH  = 3'd1;
    localparam logic [2:0] ST_NEGCYC  = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // distance limits, the top value stands for unreached
    localparam logic signed [31:0] DIST_INF = 32'sh7fff_ffff;
    localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

    // packed edge entry: from, to, duration, price, level
    localparam int EDGE_W = 76;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STAT,
        S_INIT,
        S_VRD,
        S_VCAP,
        S_ERD,
        S_ECAP,
        S_DCMP,
        S_PRD,
        S_PCAP,
        S_WCHK,
        S_WCAP,
        S_ORD,
        S_OWAIT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/sps_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/shortest_path_search_core.sv -----
// shortest path search core: edge table, bellman-ford sequencer, path output
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Directed graph engine. An add or clear transaction is acknowledged by a
// status result, registered once the output is free. A query first sets
// n distances, one vertex at a time, then runs n-1 relaxation passes (n
// passes for the level metric, the last one a negative cycle check). A pass
// reads each vertex distance and, for every reached vertex, reads every
// stored edge and relaxes each edge leaving that vertex. The edge memory and
// the distance memory each give one read per cycle, which bounds the query
// time. The walk back reads one predecessor per path vertex, then emits the
// path results, origin first. Input is refused until the last result of the
// previous transaction is registered.
module shortest_path_search_core
    import sps_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [6:0]         i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [5:0]         i_edge_from,
    input  wire logic [5:0]         i_edge_to,
    input  wire logic [23:0]        i_edge_duration,
    input  wire logic [23:0]        i_edge_price,
    input  wire logic signed [15:0] i_edge_level,
    input  wire logic [5:0]         i_query_origin,
    input  wire logic [5:0]         i_query_target,
    input  wire logic [1:0]         i_metric,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_status,
    output logic [5:0]              o_path_vertex,
    output logic signed [31:0]      o_path_total,
    output logic                    o_last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_EDGES);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int KW = (VW + 2 > 7) ? VW + 2 : 7;

    // control registers
    t_state           r_state, n_state;
    logic [6:0]       r_vcount;
    logic [EW-1:0]    r_edges, n_edges;
    logic [VW-1:0]    r_v, n_v;
    logic [AW-1:0]    r_e, n_e;
    logic [CW-1:0]    r_pass, n_pass;
    logic             r_chk, n_chk;
    logic [CW-1:0]    r_len, n_len;
    logic [CW-1:0]    r_k, n_k;
    logic             r_ovalid, n_ovalid;

    // payload registers
    logic signed [31:0] r_dv, n_dv;
    logic signed [31:0] r_w, n_w;
    logic signed [31:0] r_total, n_total;
    logic [5:0]       r_to, n_to;
    logic [5:0]       r_origin, n_origin;
    logic [5:0]       r_target, n_target;
    logic [1:0]       r_metric, n_metric;
    logic [2:0]       r_status, n_status;
    logic [VW-1:0]    r_cur, n_cur;
    logic [2:0]       r_ostatus, n_ostatus;
    logic [5:0]       r_overtex, n_overtex;
    logic signed [31:0] r_ototal, n_ototal;
    logic             r_olast, n_olast;

    // memory ports
    logic              edge_we;
    logic [AW-1:0]     edge_waddr, edge_raddr;
    logic [EDGE_W-1:0] edge_wdata, edge_rd;
    logic              dist_we;
    logic [VW-1:0]     dist_waddr, dist_raddr;
    logic signed [31:0] dist_wdata, dist_rd;
    logic              pred_we;
    logic [VW-1:0]     pred_waddr, pred_raddr;
    logic [VW:0]       pred_wdata, pred_rd;
    logic              stk_we;
    logic [VW-1:0]     stk_waddr, stk_raddr;
    logic [VW-1:0]     stk_wdata, stk_rd;

    // decoded helpers
    logic [CW-1:0]     n_use;
    logic              in_acc, out_free;
    logic              add_bad, query_bad;
    logic [5:0]        e_from, e_to;
    logic              e_hit;
    logic signed [31:0] e_weight;
    logic signed [32:0] sum;
    logic signed [31:0] cand;
    logic              relax;
    logic              e_more, v_more, pass_more;
    logic              at_origin, walk_full, pred_bad;

    sps_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (edge_we),
        .i_waddr(edge_waddr),
        .i_wdata(edge_wdata),
        .i_raddr(edge_raddr),
        .o_rdata(edge_rd)
    );

    sps_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_dist_ram (
        .i_clk  (i_clk),
        .i_we   (dist_we),
        .i_waddr(dist_waddr),
        .i_wdata(dist_wdata),
        .i_raddr(dist_raddr),
        .o_rdata(dist_rd)
    );

    sps_ram #(.WIDTH(VW + 1), .DEPTH(MAX_VERTICES)) u_pred_ram (
        .i_clk  (i_clk),
        .i_we   (pred_we),
        .i_waddr(pred_waddr),
        .i_wdata(pred_wdata),
        .i_raddr(pred_raddr),
        .o_rdata(pred_rd)
    );

    sps_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rd)
    );

    // clamp vertex count to the legal range
    always_comb begin
        if (r_vcount < 7'd2) begin
            n_use = CW'(2);
        end else if (int'(r_vcount) > MAX_VERTICES) begin
            n_use = CW'(MAX_VERTICES);
        end else begin
            n_use = CW'(r_vcount);
        end
    end

    // handshake
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;

    // request checks
    assign add_bad = (KW'(i_edge_from) >= KW'(n_use)) || (KW'(i_edge_to) >= KW'(n_use));
    assign query_bad = (i_metric != MET_DURATION && i_metric != MET_PRICE
                        && i_metric != MET_LEVEL)
                       || (KW'(i_query_origin) >= KW'(n_use))
                       || (KW'(i_query_target) >= KW'(n_use))
                       || (i_query_origin == i_query_target);

    // edge entry decode and weight select
    assign e_from = edge_rd[75:70];
    assign e_to   = edge_rd[69:64];
    assign e_hit  = (KW'(e_from) == KW'(r_v)) && (KW'(e_to) < KW'(n_use));
    always_comb begin
        case (r_metric)
            MET_DURATION: e_weight = 32'(edge_rd[63:40]);
            MET_PRICE:    e_weight = 32'(edge_rd[39:16]);
            default:      e_weight = 32'(signed'(edge_rd[15:0]));
        endcase
    end

    // saturating candidate distance and relax compare
    assign sum = 33'(r_dv) + 33'(r_w);
    always_comb begin
        if (sum[32] != sum[31]) begin
            cand = sum[32] ? DIST_MIN : DIST_INF;
        end else begin
            cand = sum[31:0];
        end
    end
    assign relax = (cand < dist_rd);

    // loop bounds
    assign e_more    = (EW'(r_e) + EW'(1)) < r_edges;
    assign v_more    = (CW'(r_v) + CW'(1)) < n_use;
    assign pass_more = (KW'(r_pass) + KW'(2)) < KW'(n_use);
    assign at_origin = (KW'(r_cur) == KW'(r_origin));
    assign walk_full = (r_len >= n_use);
    assign pred_bad  = (KW'(pred_rd) >= KW'(n_use));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_QUERY && !query_bad) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_STAT;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                if (!v_more) begin
                    n_state = S_VRD;
                end
            end
            S_VRD: n_state = S_VCAP;
            S_VCAP, S_ECAP, S_DCMP: begin
                if (r_state == S_DCMP && relax && r_chk) begin
                    n_state = S_STAT;
                end else if (r_state == S_VCAP && dist_rd != DIST_INF
                             && r_edges != '0) begin
                    n_state = S_ERD;
                end else if (r_state == S_ECAP && e_hit) begin
                    n_state = S_DCMP;
                end else if (r_state != S_VCAP && e_more) begin
                    n_state = S_ERD;
                end else if (v_more) begin
                    n_state = S_VRD;
                end else if (!r_chk && pass_more) begin
                    n_state = S_VRD;
                end else if (!r_chk && r_metric == MET_LEVEL) begin
                    n_state = S_VRD;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_ERD: n_state = S_ECAP;
            S_PRD: n_state = S_PCAP;
            S_PCAP: begin
                n_state = pred_rd[VW] ? S_STAT : S_WCHK;
            end
            S_WCHK: begin
                if (at_origin) begin
                    n_state = S_ORD;
                end else if (walk_full) begin
                    n_state = S_STAT;
                end else begin
                    n_state = S_WCAP;
                end
            end
            S_WCAP: begin
                n_state = pred_bad ? S_STAT : S_WCHK;
            end
            S_ORD: n_state = S_OWAIT;
            S_OWAIT: begin
                if (out_free) begin
                    n_state = ((r_k + CW'(1)) == r_len) ? S_IDLE : S_ORD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_edges   = r_edges;
        n_v       = r_v;
        n_e       = r_e;
        n_pass    = r_pass;
        n_chk     = r_chk;
        n_len     = r_len;
        n_k       = r_k;
        n_dv      = r_dv;
        n_w       = r_w;
        n_total   = r_total;
        n_to      = r_to;
        n_origin  = r_origin;
        n_target  = r_target;
        n_metric  = r_metric;
        n_status  = r_status;
        n_cur     = r_cur;
        n_ostatus = r_ostatus;
        n_overtex = r_overtex;
        n_ototal  = r_ototal;
        n_olast   = r_olast;
        n_ovalid  = r_ovalid && i_out_stall;

        edge_we    = 1'b0;
        edge_waddr = AW'(r_edges);
        edge_wdata = {i_edge_from, i_edge_to, i_edge_duration, i_edge_price, i_edge_level};
        edge_raddr = r_e;
        dist_we    = 1'b0;
        dist_waddr = r_v;
        dist_wdata = (KW'(r_v) == KW'(r_origin)) ? 32'sd0 : DIST_INF;
        dist_raddr = r_v;
        pred_we    = 1'b0;
        pred_waddr = r_v;
        pred_wdata = '1;
        pred_raddr = r_cur;
        stk_we     = 1'b0;
        stk_waddr  = VW'(r_len);
        stk_wdata  = VW'(pred_rd);
        stk_raddr  = VW'(r_len - r_k - CW'(1));

        case (r_state)
            // command decode
            S_IDLE: begin
                if (in_acc) begin
                    n_status = ST_BAD;
                    case (i_cmd)
                        CMD_ADD: begin
                            if (add_bad) begin
                                n_status = ST_BAD;
                            end else if (r_edges >= EW'(MAX_EDGES)) begin
                                n_status = ST_FULL;
                            end else begin
                                edge_we  = 1'b1;
                                n_edges  = r_edges + EW'(1);
                                n_status = ST_OK;
                            end
                        end
                        CMD_CLEAR: begin
                            n_edges  = '0;
                            n_status = ST_OK;
                        end
                        CMD_QUERY: begin
                            n_origin = i_query_origin;
                            n_target = i_query_target;
                            n_metric = i_metric;
                            n_v      = '0;
                        end
                        default: n_status = ST_BAD;
                    endcase
                end
            end
            // single status result
            S_STAT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_overtex = '0;
                    n_ototal  = '0;
                    n_olast   = 1'b1;
                end
            end
            // distance and predecessor sweep
            S_INIT: begin
                dist_we = 1'b1;
                pred_we = 1'b1;
                n_v     = v_more ? r_v + VW'(1) : '0;
                n_pass  = '0;
                n_chk   = 1'b0;
            end
            S_VRD: dist_raddr = r_v;
            S_ERD: edge_raddr = r_e;
            S_VCAP, S_ECAP, S_DCMP: begin
                if (r_state == S_VCAP) begin
                    n_dv = dist_rd;
                end
                if (r_state == S_ECAP) begin
                    dist_raddr = VW'(e_to);
                    n_to       = e_to;
                    n_w        = e_weight;
                end
                if (r_state == S_DCMP && relax && !r_chk) begin
                    dist_we    = 1'b1;
                    dist_waddr = VW'(r_to);
                    dist_wdata = cand;
                    pred_we    = 1'b1;
                    pred_waddr = VW'(r_to);
                    pred_wdata = {1'b0, r_v};
                    if (KW'(r_to) == KW'(r_v)) begin
                        n_dv = cand;
                    end
                end
                if (r_state == S_DCMP && relax && r_chk) begin
                    n_status = ST_NEGCYC;
                end else if (r_state == S_VCAP && dist_rd != DIST_INF
                             && r_edges != '0) begin
                    n_e = '0;
                end else if (r_state == S_ECAP && e_hit) begin
                    n_e = r_e;
                end else if (r_state != S_VCAP && e_more) begin
                    n_e = r_e + AW'(1);
                end else if (v_more) begin
                    n_v = r_v + VW'(1);
                end else if (!r_chk && pass_more) begin
                    n_v    = '0;
                    n_pass = r_pass + CW'(1);
                end else if (!r_chk && r_metric == MET_LEVEL) begin
                    n_v   = '0;
                    n_chk = 1'b1;
                end
            end
            // target lookup
            S_PRD: begin
                dist_raddr = VW'(r_target);
                pred_raddr = VW'(r_target);
            end
            S_PCAP: begin
                n_total = dist_rd;
                if (pred_rd[VW]) begin
                    n_status = ST_NOPATH;
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = VW'(r_target);
                    n_len     = CW'(1);
                    n_cur     = VW'(r_target);
                end
            end
            // walk back along predecessors
            S_WCHK: begin
                pred_raddr = r_cur;
                n_k        = '0;
                n_status   = ST_NEGCYC;
            end
            S_WCAP: begin
                if (!pred_bad) begin
                    stk_we    = 1'b1;
                    stk_waddr = VW'(r_len);
                    stk_wdata = VW'(pred_rd);
                    n_cur     = VW'(pred_rd);
                    n_len     = r_len + CW'(1);
                end
            end
            // path results, origin first
            S_ORD: stk_raddr = VW'(r_len - r_k - CW'(1));
            S_OWAIT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_OK;
                    n_overtex = 6'(stk_rd);
                    n_ototal  = r_total;
                    n_olast   = (r_k + CW'(1)) == r_len;
                    n_k       = r_k + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= 7'd5;
            r_edges  <= '0;
            r_ovalid <= 1'b0;
            r_v      <= '0;
            r_e      <= '0;
            r_pass   <= '0;
            r_chk    <= 1'b0;
            r_len    <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_edges  <= n_edges;
            r_ovalid <= n_ovalid;
            r_v      <= n_v;
            r_e      <= n_e;
            r_pass   <= n_pass;
            r_chk    <= n_chk;
            r_len    <= n_len;
            r_k      <= n_k;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_dv      <= n_dv;
        r_w       <= n_w;
        r_total   <= n_total;
        r_to      <= n_to;
        r_origin  <= n_origin;
        r_target  <= n_target;
        r_metric  <= n_metric;
        r_status  <= n_status;
        r_cur     <= n_cur;
        r_ostatus <= n_ostatus;
        r_overtex <= n_overtex;
        r_ototal  <= n_ototal;
        r_olast   <= n_olast;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_path_vertex = r_overtex;
    assign o_path_total  = r_ototal;
    assign o_last        = r_olast;

    // checks
    `SPS_ASSERT_IMP(a_edges_bound, i_clk, i_rst_n, 1'b1, r_edges <= EW'(MAX_EDGES))
    `SPS_ASSERT_NXT(a_ack_path, i_clk, i_rst_n, in_acc && i_cmd != CMD_QUERY, r_state == S_STAT)
    `SPS_ASSERT_IMP(a_walk_len, i_clk, i_rst_n, r_state == S_WCHK, r_len <= n_use && r_len != '0)
    `SPS_ASSERT_IMP(a_emit_idx, i_clk, i_rst_n, r_state == S_ORD || r_state == S_OWAIT, r_k < r_len)

endmodule

`default_nettype wire
